@@ rtl/core/sfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared types, codes and constants of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Default width of the residual time register.
  localparam int SFS_TIME_WIDTH = 16;
  // Largest number of frames a sprite sheet may hold.
  localparam int SFS_MAX_FRAMES = 4096;
  // Width of the frame duration register and of the divider's divisor.
  localparam int SFS_DUR_W = 16;
  // Width of the configuration write data.
  localparam int SFS_CFG_DATA_W = 16;

  // Command codes.
  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_PLAY_RESTART  = 3'd1,
    OP_PLAY_CONTINUE = 3'd2,
    OP_STOP          = 3'd3,
    OP_RESET         = 3'd4,
    OP_SHOW          = 3'd5
  } sfs_op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CLIP_START     = 3'd0,
    CFG_CLIP_LENGTH    = 3'd1,
    CFG_FRAME_DURATION = 3'd2,
    CFG_LOOP_ENABLE    = 3'd3,
    CFG_REVERSE        = 3'd4,
    CFG_SHEET_COLUMNS  = 3'd5,
    CFG_SHEET_ROWS     = 3'd6
  } sfs_cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TIME,
    ST_DIV_STEP,
    ST_GRID,
    ST_DIV_GRID,
    ST_DONE
  } sfs_state_t;

  // Command payload.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] elapsed_ticks;
    logic [11:0] fixed_frame;
  } sfs_cmd_t;

  // Response payload.
  typedef struct packed {
    logic        accepted;
    logic [11:0] frame_index;
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
    logic        is_playing;
    logic        is_finished;
  } sfs_rsp_t;

  // Clip settings and derived sheet geometry.
  typedef struct packed {
    logic [11:0] clip_start;
    logic [12:0] clip_length;
    logic [15:0] frame_duration;
    logic        loop_enable;
    logic        reverse;
    logic [6:0]  eff_cols;
    logic [12:0] capacity;
    logic        clip_valid;
    logic [13:0] first_frame;
    logic [13:0] end_frame;
  } sfs_cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/sfs_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer divider
// Restoring divider that retires one quotient bit per cycle. Shared by the
// time, step and grid divisions of the sequencer.
// ----------------------------------------------------------------------------
module sfs_divider #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {remainder, quotient[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor_q};
    fits  = (trial >= {1'b0, divisor_q});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIVIDEND_W-2:0], fits};
      remainder <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sfs_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer configuration registers
// Holds the clip and sheet settings and derives the effective grid, the
// sheet capacity, clip validity and the clip's first and end frames.
// ----------------------------------------------------------------------------
module sfs_cfg_regs
  import sfs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [2:0]                cfg_index,
  input  logic [SFS_CFG_DATA_W-1:0] cfg_data,
  output sfs_cfg_t                  cfg
);

  logic [11:0] clip_start;
  logic [12:0] clip_length;
  logic [15:0] frame_duration;
  logic        loop_enable;
  logic        reverse;
  logic [6:0]  sheet_columns;
  logic [6:0]  sheet_rows;

  logic [6:0]  eff_cols;
  logic [6:0]  eff_rows;
  logic [13:0] cells;
  logic [12:0] capacity;
  logic [12:0] len_min1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_start     <= 12'd0;
      clip_length    <= 13'd1;
      frame_duration <= 16'd1;
      loop_enable    <= 1'b0;
      reverse        <= 1'b0;
      sheet_columns  <= 7'd1;
      sheet_rows     <= 7'd1;
    end else if (cfg_valid) begin
      unique case (sfs_cfg_idx_t'(cfg_index))
        CFG_CLIP_START:     clip_start     <= cfg_data[11:0];
        CFG_CLIP_LENGTH:    clip_length    <= cfg_data[12:0];
        CFG_FRAME_DURATION: frame_duration <= cfg_data[15:0];
        CFG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
        CFG_REVERSE:        reverse        <= cfg_data[0];
        CFG_SHEET_COLUMNS:  sheet_columns  <= cfg_data[6:0];
        CFG_SHEET_ROWS:     sheet_rows     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Saturate the grid to 1..64 on each axis and cap the cell count.
  always_comb begin
    if (sheet_columns == 7'd0) begin
      eff_cols = 7'd1;
    end else if (sheet_columns > 7'd64) begin
      eff_cols = 7'd64;
    end else begin
      eff_cols = sheet_columns;
    end
    if (sheet_rows == 7'd0) begin
      eff_rows = 7'd1;
    end else if (sheet_rows > 7'd64) begin
      eff_rows = 7'd64;
    end else begin
      eff_rows = sheet_rows;
    end
    cells = 14'(eff_cols) * 14'(eff_rows);
    if (32'(cells) > SFS_MAX_FRAMES) begin
      capacity = 13'(SFS_MAX_FRAMES);
    end else begin
      capacity = cells[12:0];
    end
    len_min1 = (clip_length == 13'd0) ? 13'd1 : clip_length;
  end

  // Settings and derived values handed to the sequencer.
  always_comb begin
    cfg.clip_start     = clip_start;
    cfg.clip_length    = clip_length;
    cfg.frame_duration = frame_duration;
    cfg.loop_enable    = loop_enable;
    cfg.reverse        = reverse;
    cfg.eff_cols       = eff_cols;
    cfg.capacity       = capacity;
    cfg.clip_valid     = (clip_length != 13'd0) &&
                         (14'(clip_start) + 14'(clip_length) <= 14'(capacity)) &&
                         (frame_duration != 16'd0);
    cfg.first_frame    = reverse ? 14'(clip_start) + 14'(len_min1) - 14'd1
                                 : 14'(clip_start);
    cfg.end_frame      = reverse ? 14'(clip_start)
                                 : 14'(clip_start) + 14'(clip_length) - 14'd1;
  end

endmodule
`default_nettype wire

@@ rtl/core/sprite_frame_sequencer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps a sprite-sheet animation player on commands and reports the shown
// frame with its grid column and row.
//
// Commands arrive on the cmd channel and each produces one response on the
// rsp channel. cfg writes set the clip and sheet registers; the user must make
// them only while no command is in flight, as the block itself does not enforce
// it. All divisions run through one shared restoring divider that retires one
// bit per cycle over a dividend of max(TIME_WIDTH, 16) + 1 bits. A command
// other than a tick takes one grid division. A tick that advances takes up
// to three divisions (time by frame duration, steps modulo clip length, frame
// by columns). cmd_ready is high only while the sequencer is idle, one command
// at a time. The response sits in an output register: the next command is
// taken while it waits, and a finished result waits in the sequencer while the
// receiver stalls. Reset clears the player state and response valid, and loads
// register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit
  import sfs_pkg::*;
#(
  parameter int TIME_WIDTH = SFS_TIME_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  sfs_cmd_t                  cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output sfs_rsp_t                  rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [SFS_CFG_DATA_W-1:0] cfg_data
);

  localparam int DIV_W = ((TIME_WIDTH > SFS_DUR_W) ? TIME_WIDTH : SFS_DUR_W) + 1;

  sfs_cfg_t cfg;

  sfs_state_t            state, state_next;
  logic [11:0]           current_frame, frame_next;
  logic [TIME_WIDTH-1:0] residual_time, residual_next;
  logic                  playing_flag, playing_next;
  logic                  finished_flag, finished_next;
  logic                  clip_active, clip_active_next;
  logic                  acc, acc_next;
  logic [11:0]           local_pos, local_next;
  logic                  rsp_load;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [SFS_DUR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;
  logic [SFS_DUR_W-1:0]  div_rem;

  logic [DIV_W-1:0]      elapsed_sum;
  logic [11:0]           tick_local;
  logic [12:0]           remaining;
  logic [11:0]           step_pos;

  // Clamp a frame number to the last cell of the sheet.
  function automatic logic [11:0] clamp_frame(input logic [13:0] f, input logic [12:0] cap);
    logic [12:0] last;
    last = cap - 13'd1;
    if (f > 14'(last)) begin
      return last[11:0];
    end
    return f[11:0];
  endfunction

  assign cfg_ready = 1'b1;

  sfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfs_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (SFS_DUR_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Clip-local position and frames left until the clip end.
  always_comb begin
    logic [11:0] d;
    logic [12:0] cnt_last;
    d        = current_frame - cfg.clip_start;
    cnt_last = cfg.clip_length - 13'd1;
    if (current_frame < cfg.clip_start) begin
      tick_local = 12'd0;
    end else if (13'(d) > cnt_last) begin
      tick_local = cnt_last[11:0];
    end else begin
      tick_local = d;
    end
    remaining   = cfg.reverse ? 13'(tick_local) + 13'd1
                              : cfg.clip_length - 13'(tick_local);
    elapsed_sum = DIV_W'(residual_time) + DIV_W'(cmd.elapsed_ticks);
  end

  // Wrapped position after advancing by the step count modulo clip length.
  always_comb begin
    logic [13:0] sum;
    logic [13:0] wrapped;
    if (cfg.reverse) begin
      sum = 14'(local_pos) + 14'(cfg.clip_length) - 14'(div_rem[12:0]);
    end else begin
      sum = 14'(local_pos) + 14'(div_rem[12:0]);
    end
    wrapped  = (sum >= 14'(cfg.clip_length)) ? sum - 14'(cfg.clip_length) : sum;
    step_pos = wrapped[11:0];
  end

  // Sequencer: next state, player state updates and divider requests.
  always_comb begin
    state_next       = state;
    frame_next       = current_frame;
    residual_next    = residual_time;
    playing_next     = playing_flag;
    finished_next    = finished_flag;
    clip_active_next = clip_active;
    acc_next         = acc;
    local_next       = local_pos;
    div_start        = 1'b0;
    div_dividend     = '0;
    div_divisor      = '0;
    rsp_load         = 1'b0;
    cmd_ready        = (state == ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          acc_next   = 1'b1;
          state_next = ST_GRID;
          unique case (sfs_op_t'(cmd.opcode))
            OP_TICK: begin
              if (playing_flag && (cmd.elapsed_ticks != 16'd0) && clip_active &&
                  (cfg.frame_duration != 16'd0)) begin
                if (!cfg.clip_valid) begin
                  playing_next = 1'b0;
                end else begin
                  div_start    = 1'b1;
                  div_dividend = elapsed_sum;
                  div_divisor  = cfg.frame_duration;
                  state_next   = ST_DIV_TIME;
                end
              end
            end
            OP_PLAY_RESTART, OP_PLAY_CONTINUE: begin
              if (!cfg.clip_valid) begin
                acc_next = 1'b0;
              end else begin
                if ((sfs_op_t'(cmd.opcode) == OP_PLAY_RESTART) || !clip_active) begin
                  clip_active_next = 1'b1;
                  frame_next       = clamp_frame(cfg.first_frame, cfg.capacity);
                  residual_next    = '0;
                end
                playing_next  = 1'b1;
                finished_next = 1'b0;
              end
            end
            OP_STOP: begin
              playing_next = 1'b0;
            end
            OP_RESET: begin
              frame_next    = clamp_frame(clip_active ? cfg.first_frame : 14'd0,
                                          cfg.capacity);
              residual_next = '0;
              playing_next  = 1'b0;
              finished_next = 1'b0;
            end
            OP_SHOW: begin
              frame_next    = clamp_frame(14'(cmd.fixed_frame), cfg.capacity);
              residual_next = '0;
              playing_next  = 1'b0;
              finished_next = 1'b0;
            end
            default: begin
              acc_next = 1'b0;
            end
          endcase
        end
      end

      // Whole frames elapsed and the new residual.
      ST_DIV_TIME: begin
        if (div_done) begin
          residual_next = TIME_WIDTH'(div_rem);
          if (div_quo == '0) begin
            state_next = ST_GRID;
          end else if (!cfg.loop_enable && (div_quo >= DIV_W'(remaining))) begin
            frame_next    = clamp_frame(cfg.end_frame, cfg.capacity);
            playing_next  = 1'b0;
            finished_next = 1'b1;
            residual_next = '0;
            state_next    = ST_GRID;
          end else begin
            local_next   = tick_local;
            div_start    = 1'b1;
            div_dividend = div_quo;
            div_divisor  = SFS_DUR_W'(cfg.clip_length);
            state_next   = ST_DIV_STEP;
          end
        end
      end

      // Step count modulo clip length gives the advance.
      ST_DIV_STEP: begin
        if (div_done) begin
          frame_next = clamp_frame(14'(cfg.clip_start) + 14'(step_pos), cfg.capacity);
          state_next = ST_GRID;
        end
      end

      // Split the frame into grid column and row.
      ST_GRID: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(current_frame);
        div_divisor  = SFS_DUR_W'(cfg.eff_cols);
        state_next   = ST_DIV_GRID;
      end

      ST_DIV_GRID: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and player state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_frame <= 12'd0;
      residual_time <= '0;
      playing_flag  <= 1'b0;
      finished_flag <= 1'b0;
      clip_active   <= 1'b0;
    end else begin
      state         <= state_next;
      current_frame <= frame_next;
      residual_time <= residual_next;
      playing_flag  <= playing_next;
      finished_flag <= finished_next;
      clip_active   <= clip_active_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    acc       <= acc_next;
    local_pos <= local_next;
  end

  // Output register; a transfer frees it for the next result.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.accepted    <= acc;
      rsp.frame_index <= current_frame;
      rsp.cell_column <= div_rem[5:0];
      rsp.cell_row    <= (div_quo > DIV_W'(63)) ? 6'd63 : div_quo[5:0];
      rsp.is_playing  <= playing_flag;
      rsp.is_finished <= finished_flag;
    end
  end

  // A clip is never both playing and finished.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(playing_flag && finished_flag))
    else $error("playing and finished flags both set");

  // A command transfer always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after a command transfer");

  // The divider only completes while the sequencer waits on it.
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_TIME || state == ST_DIV_STEP || state == ST_DIV_GRID))
    else $error("divider finished outside a division state");

  // A finished result reaches the output register once it is free.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!rsp_valid || rsp_ready)) |=> (rsp_valid && state == ST_IDLE))
    else $error("result not loaded into the output register");

endmodule
`default_nettype wire
